### src/ncfr_pkg.sv
// ----------------------------------------------------------------------------
// ncfr_pkg
// shared types, constants and microcode encodings of the notch ramp controller
// ----------------------------------------------------------------------------
package ncfr_pkg;

    // fixed point format of frequencies
    localparam int FREQ_FRAC_BITS = 16;

    // field widths
    localparam int NOTCH_W = 4;
    localparam int RATE_W  = 16;
    localparam int US_W    = 20;
    localparam int FREQ_W  = 24;
    localparam int ANGLE_W = 27;
    localparam int TIME_W  = 32;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // stream payload widths
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 96;

    // datapath widths
    localparam int ACC_W         = 64;
    localparam int QUO_W         = 32;
    localparam int REM_W         = ANGLE_W;
    localparam int DIV_BITS_STEP = 2;
    localparam int DIV_ITERS     = QUO_W / DIV_BITS_STEP;
    localparam int CNT_W         = $clog2(DIV_ITERS);

    // 2*pi in Q32, split into a low word and the integer part
    localparam logic [31:0] TWO_PI_LO = 32'h487E_D511;
    localparam logic [2:0]  TWO_PI_HI = 3'h6;
    localparam int          ANG_SHIFT = FREQ_FRAC_BITS + 16;
    localparam logic [ACC_W-1:0] ANG_ROUND = ACC_W'(1) << (FREQ_FRAC_BITS + 15);

    // rates are Q8.8, steps are in the frequency format
    localparam int RATE_SHIFT = FREQ_FRAC_BITS - 8;

    // step divisors: microseconds per second times the notch denominator
    localparam logic [REM_W-1:0] DIV_EMERG = REM_W'(1000000);
    localparam logic [REM_W-1:0] DIV_BRAKE = REM_W'(8000000);
    localparam logic [REM_W-1:0] DIV_POWER = REM_W'(5000000);

    // register reset values
    localparam logic [RATE_W-1:0] ACCEL_RESET = RATE_W'(1024);
    localparam logic [RATE_W-1:0] BRAKE_RESET = RATE_W'(3072);
    localparam logic [RATE_W-1:0] EMERG_RESET = RATE_W'(5120);
    localparam logic [FREQ_W-1:0] LIMIT_RESET = FREQ_W'(6553600);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL = 2'd0,
        CFG_BRAKE = 2'd1,
        CFG_EMERG = 2'd2,
        CFG_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RC_EMERG,
        RC_BRAKE,
        RC_HOLD,
        RC_POWER
    } t_rate_cls;

    // microprogram step addresses
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_SCALE,
        ST_DLD_STEP,
        ST_DIV_STEP,
        ST_FREQ,
        ST_ANG_LO,
        ST_ANG_HI,
        ST_ANG_SAT,
        ST_TIME_MUL,
        ST_DLD_TIME,
        ST_DIV_TIME,
        ST_TIME,
        ST_DONE,
        ST_RET
    } t_step;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_MUL_RATE,
        OP_MUL_SCALE,
        OP_DIV_LD_STEP,
        OP_DIV_LD_TIME,
        OP_DIV_ITER,
        OP_FREQ,
        OP_ANG_LO,
        OP_ANG_HI,
        OP_ANG_SAT,
        OP_MUL_TIME,
        OP_TIME,
        OP_FINISH
    } t_uop;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_DIV_OVF,
        C_DIV_BUSY,
        C_NO_RESCALE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic div_ovf;
        logic div_busy;
        logic no_rescale;
    } t_dp_status;

    typedef struct packed {
        logic [RATE_W-1:0] accel_ceiling;
        logic [RATE_W-1:0] brake_ceiling;
        logic [RATE_W-1:0] emergency_rate;
        logic [FREQ_W-1:0] freq_limit;
    } t_cfg;

    typedef struct packed {
        logic [NOTCH_W-1:0] notch_raw;
        logic               emo_healthy;
        logic               reverse_request;
        logic [US_W-1:0]    elapsed_us;
        logic [FREQ_W-1:0]  present_freq;
        logic [ANGLE_W-1:0] present_angle_freq;
        logic               present_brake;
        logic               free_run;
        logic               allow_time_rescale;
        logic [TIME_W-1:0]  sine_time;
    } t_tick_in;

    typedef struct packed {
        logic [NOTCH_W-1:0] active_notch;
        logic               emo_latched;
        logic               reverse_active;
        logic               reverse_changed;
        logic               brake;
        logic               coast;
        logic [FREQ_W-1:0]  new_freq;
        logic [ANGLE_W-1:0] new_angle_freq;
        logic [TIME_W-1:0]  new_sine_time;
    } t_tick_out;

endpackage

### src/ncfr_sequencer.sv
// ----------------------------------------------------------------------------
// ncfr_sequencer
// step counter and microprogram rom with conditional jumps
// ----------------------------------------------------------------------------
module ncfr_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_busy,
    input  ncfr_pkg::t_dp_status i_status,
    output ncfr_pkg::t_uop      o_op
);
    import ncfr_pkg::*;

    t_step  r_upc;
    t_step  n_upc;
    t_uword w_uword;
    logic   w_jump;

    // microprogram
    always_comb begin
        unique case (r_upc)
            ST_IDLE:     w_uword = '{OP_CAPTURE,     C_NO_REQ,     ST_IDLE};
            ST_RATE:     w_uword = '{OP_MUL_RATE,    C_NEVER,      ST_IDLE};
            ST_SCALE:    w_uword = '{OP_MUL_SCALE,   C_NEVER,      ST_IDLE};
            ST_DLD_STEP: w_uword = '{OP_DIV_LD_STEP, C_DIV_OVF,    ST_FREQ};
            ST_DIV_STEP: w_uword = '{OP_DIV_ITER,    C_DIV_BUSY,   ST_DIV_STEP};
            ST_FREQ:     w_uword = '{OP_FREQ,        C_NEVER,      ST_IDLE};
            ST_ANG_LO:   w_uword = '{OP_ANG_LO,      C_NEVER,      ST_IDLE};
            ST_ANG_HI:   w_uword = '{OP_ANG_HI,      C_NEVER,      ST_IDLE};
            ST_ANG_SAT:  w_uword = '{OP_ANG_SAT,     C_NEVER,      ST_IDLE};
            ST_TIME_MUL: w_uword = '{OP_MUL_TIME,    C_NO_RESCALE, ST_DONE};
            ST_DLD_TIME: w_uword = '{OP_DIV_LD_TIME, C_DIV_OVF,    ST_TIME};
            ST_DIV_TIME: w_uword = '{OP_DIV_ITER,    C_DIV_BUSY,   ST_DIV_TIME};
            ST_TIME:     w_uword = '{OP_TIME,        C_NEVER,      ST_IDLE};
            ST_DONE:     w_uword = '{OP_FINISH,      C_OUT_BUSY,   ST_DONE};
            ST_RET:      w_uword = '{OP_NOP,         C_ALWAYS,     ST_IDLE};
            default:     w_uword = '{OP_NOP,         C_ALWAYS,     ST_IDLE};
        endcase
    end

    always_comb begin
        unique case (w_uword.cond)
            C_NEVER:      w_jump = 1'b0;
            C_ALWAYS:     w_jump = 1'b1;
            C_NO_REQ:     w_jump = ~i_in_valid;
            C_DIV_OVF:    w_jump = i_status.div_ovf;
            C_DIV_BUSY:   w_jump = i_status.div_busy;
            C_NO_RESCALE: w_jump = i_status.no_rescale;
            C_OUT_BUSY:   w_jump = i_out_busy;
            default:      w_jump = 1'b1;
        endcase
        n_upc = w_jump ? w_uword.target : t_step'(r_upc + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op = w_uword.op;

endmodule

### src/ncfr_datapath.sv
// ----------------------------------------------------------------------------
// ncfr_datapath
// multipliers, radix-4 divider and tick state, driven by the microcode
// ----------------------------------------------------------------------------
module ncfr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ncfr_pkg::t_uop       i_op,
    input  ncfr_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    input  ncfr_pkg::t_tick_in   i_tick,
    output ncfr_pkg::t_dp_status o_status,
    output ncfr_pkg::t_tick_out  o_result
);
    import ncfr_pkg::*;

    // persistent state
    logic r_emo;
    logic r_rev;

    // per tick registers
    t_tick_in            r_tick;
    logic                r_changed;
    logic [NOTCH_W-1:0]  r_notch;
    logic [NOTCH_W-1:0]  r_mult;
    t_rate_cls           r_cls;
    logic [ACC_W-1:0]    r_acc;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    r_dsr;
    logic [QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [FREQ_W-1:0]   r_nf;
    logic [ANGLE_W-1:0]  r_na;
    logic [TIME_W-1:0]   r_ot;

    // capture logic
    logic               w_accept;
    logic               w_emo_next;
    logic [NOTCH_W-1:0] w_notch;
    logic               w_rev_flip;
    t_rate_cls          w_cls;
    logic [NOTCH_W-1:0] w_mult;

    // arithmetic
    logic [RATE_W-1:0]       w_base;
    logic [RATE_W+US_W-1:0]  w_prod_rate;
    logic [RATE_W+US_W+NOTCH_W-1:0] w_prod_scale;
    logic [FREQ_W+32-1:0]    w_prod_lo;
    logic [FREQ_W+3-1:0]     w_prod_hi;
    logic [TIME_W+ANGLE_W-1:0] w_prod_time;
    logic [ACC_W-1:0]        w_ang_shift;
    logic [ANGLE_W-1:0]      w_na;
    logic [REM_W-1:0]        w_step_dsr;
    logic [REM_W-1:0]        w_dsr_sel;
    logic                    w_div_ovf;
    logic [REM_W:0]          w_trial;
    logic [REM_W-1:0]        w_rem_nx;
    logic [QUO_W-1:0]        w_quo_nx;
    logic [FREQ_W-1:0]       w_brake_nf;
    logic [FREQ_W+8:0]       w_cand;
    logic [FREQ_W-1:0]       w_nf;

    assign w_accept   = (i_op == OP_CAPTURE) && i_in_valid;
    assign w_emo_next = r_emo | ~i_tick.emo_healthy;
    assign w_notch    = w_emo_next ? '0 : i_tick.notch_raw;
    assign w_rev_flip = (i_tick.present_angle_freq == '0) && (i_tick.present_freq == '0)
                     && (i_tick.notch_raw == '0) && (i_tick.reverse_request != r_rev);

    // notch to rate class and numerator
    always_comb begin
        priority if (w_notch == 4'd0) begin
            w_cls  = RC_EMERG;
            w_mult = 4'd1;
        end else if (w_notch <= 4'd8) begin
            w_cls  = RC_BRAKE;
            w_mult = 4'd9 - w_notch;
        end else if (w_notch >= 4'd11) begin
            w_cls  = RC_POWER;
            w_mult = w_notch - 4'd10;
        end else begin
            w_cls  = RC_HOLD;
            w_mult = 4'd0;
        end
    end

    always_comb begin
        unique case (r_cls)
            RC_EMERG: begin
                w_base     = i_cfg.emergency_rate;
                w_step_dsr = DIV_EMERG;
            end
            RC_BRAKE: begin
                w_base     = i_cfg.brake_ceiling;
                w_step_dsr = DIV_BRAKE;
            end
            RC_POWER: begin
                w_base     = i_cfg.accel_ceiling;
                w_step_dsr = DIV_POWER;
            end
            default: begin
                w_base     = '0;
                w_step_dsr = DIV_EMERG;
            end
        endcase
    end

    assign w_prod_rate  = w_base * r_tick.elapsed_us;
    assign w_prod_scale = r_acc[RATE_W+US_W-1:0] * r_mult;
    assign w_prod_lo    = r_nf * TWO_PI_LO;
    assign w_prod_hi    = r_nf * TWO_PI_HI;
    assign w_prod_time  = r_tick.sine_time * r_tick.present_angle_freq;

    assign w_ang_shift = r_acc >> ANG_SHIFT;
    assign w_na = (|w_ang_shift[ACC_W-1:ANGLE_W]) ? '1 : w_ang_shift[ANGLE_W-1:0];

    // quotient would not fit in 32 bits: saturate and skip the iterations
    assign w_dsr_sel = (i_op == OP_DIV_LD_TIME) ? r_na : w_step_dsr;
    assign w_div_ovf = r_acc[ACC_W-1:QUO_W] >= QUO_W'(w_dsr_sel);

    // two restoring steps per cycle
    always_comb begin
        w_rem_nx = r_rem;
        w_quo_nx = r_quo;
        w_trial  = '0;
        for (int i = 0; i < DIV_BITS_STEP; i++) begin
            w_trial  = {w_rem_nx, w_quo_nx[QUO_W-1]};
            w_quo_nx = {w_quo_nx[QUO_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                w_trial     = w_trial - {1'b0, r_dsr};
                w_quo_nx[0] = 1'b1;
            end
            w_rem_nx = w_trial[REM_W-1:0];
        end
    end

    // frequency update with clamp
    assign w_brake_nf = (r_quo >= QUO_W'(r_tick.present_freq)) ? '0
                      : r_tick.present_freq - r_quo[FREQ_W-1:0];

    always_comb begin
        unique case (r_cls)
            RC_EMERG, RC_BRAKE: w_cand = (FREQ_W+9)'(w_brake_nf);
            RC_POWER: w_cand = (FREQ_W+9)'(r_tick.present_freq) + (FREQ_W+9)'(r_quo);
            default:  w_cand = (FREQ_W+9)'(r_tick.present_freq);
        endcase
        w_nf = (w_cand > (FREQ_W+9)'(i_cfg.freq_limit)) ? i_cfg.freq_limit
                                                       : w_cand[FREQ_W-1:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emo <= 1'b0;
            r_rev <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_accept) begin
                r_emo <= w_emo_next;
                if (w_rev_flip) begin
                    r_rev <= i_tick.reverse_request;
                end
            end
            if (i_op == OP_DIV_LD_STEP || i_op == OP_DIV_LD_TIME) begin
                r_cnt <= '0;
            end else if (i_op == OP_DIV_ITER) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CAPTURE: begin
                if (w_accept) begin
                    r_tick    <= i_tick;
                    r_changed <= w_rev_flip;
                    r_notch   <= w_notch;
                    r_mult    <= w_mult;
                    r_cls     <= w_cls;
                    r_ot      <= i_tick.sine_time;
                end
            end
            OP_MUL_RATE:  r_acc <= ACC_W'(w_prod_rate);
            OP_MUL_SCALE: r_acc <= ACC_W'(w_prod_scale) << RATE_SHIFT;
            OP_DIV_LD_STEP, OP_DIV_LD_TIME: begin
                r_dsr <= w_dsr_sel;
                r_rem <= r_acc[QUO_W+REM_W-1:QUO_W];
                r_quo <= w_div_ovf ? '1 : r_acc[QUO_W-1:0];
            end
            OP_DIV_ITER: begin
                r_rem <= w_rem_nx;
                r_quo <= w_quo_nx;
            end
            OP_FREQ:     r_nf  <= w_nf;
            OP_ANG_LO:   r_acc <= ACC_W'(w_prod_lo);
            OP_ANG_HI:   r_acc <= r_acc + ACC_W'({w_prod_hi, 32'd0}) + ANG_ROUND;
            OP_ANG_SAT:  r_na  <= w_na;
            OP_MUL_TIME: r_acc <= ACC_W'(w_prod_time);
            OP_TIME:     r_ot  <= r_quo;
            default: begin
            end
        endcase
    end

    assign o_status.div_ovf    = w_div_ovf;
    assign o_status.div_busy   = r_cnt != CNT_W'(DIV_ITERS - 1);
    assign o_status.no_rescale = r_tick.free_run | ~r_tick.allow_time_rescale | (r_na == '0);

    always_comb begin
        o_result.active_notch    = r_notch;
        o_result.emo_latched     = r_emo;
        o_result.reverse_active  = r_rev;
        o_result.reverse_changed = r_changed;
        o_result.coast           = (r_notch == 4'd9);
        o_result.brake           = (r_notch == 4'd9) ? r_tick.present_brake : (r_notch <= 4'd8);
        o_result.new_freq        = r_tick.free_run ? r_tick.present_freq : r_nf;
        o_result.new_angle_freq  = r_tick.free_run ? r_tick.present_angle_freq : r_na;
        o_result.new_sine_time   = r_ot;
    end

endmodule

### src/notch_frequency_ramp_controller.sv
// ----------------------------------------------------------------------------
// notch_frequency_ramp_controller
// throttle notch to generator frequency ramp, angle and phase time update
// ----------------------------------------------------------------------------
// usage
//   one control tick enters on the s_axis request channel, one result leaves
//   on the m_axis channel for every tick, in order
//   a microcoded sequencer runs the tick through separate multipliers and a
//   two bit per cycle divider: the ramp step division always runs, the phase
//   time division only when rescaling applies, and a saturated quotient skips
//   the divider iterations; a new tick is taken only after the previous one
//   has gone to the output register
//   s_axis_tready is high only while the sequencer waits for a tick
//   the result sits in an output register; a stalled receiver holds it there
//   while the next tick is already being worked on, and the sequencer waits
//   at its last step until that register frees up
//   reset (synchronous, active low) clears the emergency latch, forward
//   direction, the register file to its defaults and the output valid flag
//   config writes land on i_cfg_we; write only while no tick is in flight
// ----------------------------------------------------------------------------
module notch_frequency_ramp_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config register write
    input  logic                                i_cfg_we,
    input  logic [ncfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ncfr_pkg::CFG_W-1:0]          i_cfg_data,
    // tick request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // notch_raw, emo_healthy, reverse_request, elapsed_us, present_freq,
    // present_angle_freq, present_brake, free_run, allow_time_rescale, sine_time
    input  logic [ncfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // active_notch, emo_latched, reverse_active, reverse_changed, brake, coast,
    // new_freq, new_angle_freq, new_sine_time, zero fill
    output logic [ncfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import ncfr_pkg::*;

    // register file
    t_cfg        r_cfg;

    // output register
    logic        r_out_valid;
    t_tick_out   r_out;

    t_uop        w_op;
    t_dp_status  w_status;
    t_tick_in    w_tick;
    t_tick_out   w_result;
    logic        w_out_busy;
    logic        w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_ceiling  <= ACCEL_RESET;
            r_cfg.brake_ceiling  <= BRAKE_RESET;
            r_cfg.emergency_rate <= EMERG_RESET;
            r_cfg.freq_limit     <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCEL: r_cfg.accel_ceiling  <= i_cfg_data[RATE_W-1:0];
                CFG_BRAKE: r_cfg.brake_ceiling  <= i_cfg_data[RATE_W-1:0];
                CFG_EMERG: r_cfg.emergency_rate <= i_cfg_data[RATE_W-1:0];
                CFG_LIMIT: r_cfg.freq_limit     <= i_cfg_data[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack the request, first field in the low bits
    assign w_tick.notch_raw          = s_axis_tdata[3:0];
    assign w_tick.emo_healthy        = s_axis_tdata[4];
    assign w_tick.reverse_request    = s_axis_tdata[5];
    assign w_tick.elapsed_us         = s_axis_tdata[25:6];
    assign w_tick.present_freq       = s_axis_tdata[49:26];
    assign w_tick.present_angle_freq = s_axis_tdata[76:50];
    assign w_tick.present_brake      = s_axis_tdata[77];
    assign w_tick.free_run           = s_axis_tdata[78];
    assign w_tick.allow_time_rescale = s_axis_tdata[79];
    assign w_tick.sine_time          = s_axis_tdata[111:80];

    // the sequencer holds at its finish step while the result slot is taken
    assign w_out_busy = r_out_valid && !m_axis_tready;
    assign w_out_load = (w_op == OP_FINISH) && !w_out_busy;

    ncfr_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (w_out_busy),
        .i_status   (w_status),
        .o_op       (w_op)
    );

    ncfr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .i_tick     (w_tick),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign s_axis_tready = (w_op == OP_CAPTURE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    // pack the result, first field in the low bits
    assign m_axis_tdata = {4'd0,
                           r_out.new_sine_time,
                           r_out.new_angle_freq,
                           r_out.new_freq,
                           r_out.coast,
                           r_out.brake,
                           r_out.reverse_changed,
                           r_out.reverse_active,
                           r_out.emo_latched,
                           r_out.active_notch};

    // a latched emergency always reports notch zero
    a_emo_forces_notch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.emo_latched) |-> (r_out.active_notch == '0))
        else $error("emergency latched with nonzero notch");

    // coast only comes from the neutral notch and never with emergency
    a_coast_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.coast) |-> (r_out.active_notch == 4'd9 && !r_out.emo_latched))
        else $error("coast without neutral notch");

    // one tick at a time: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while a tick is in flight");

    // the result register is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_out)))
        else $error("pending result lost");

endmodule
